// ----- rtl/sha1h_pkg.sv -----
package sha1h_pkg;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_AFTER_FINISH = 2'd1;
    localparam logic [1:0] ST_TOO_LONG     = 2'd2;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int         NUM_ROUNDS = 80;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [3:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] digest_word;
        logic        last;
    } t_out_item;

    // One write into the block buffer: a single byte or a whole word.
    typedef struct packed {
        logic        en;
        logic        whole;
        logic [5:0]  addr;
        logic [31:0] data;
    } t_buf_wr;

    typedef struct packed {
        logic       init;
        logic       load;
        logic       round;
        logic       add;
        logic [6:0] t;
    } t_core_ctl;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

endpackage

// ----- rtl/sha1h_buf.sv -----
module sha1h_buf (
    input  logic             i_clk,
    input  sha1h_pkg::t_buf_wr i_wr,
    input  logic [3:0]       i_raddr,
    output logic [31:0]      o_rdata
);
    import sha1h_pkg::*;

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;
    logic [4:0]  lane_lsb;

    // Byte 0 of a word is its most significant byte.
    assign lane_lsb = {~i_wr.addr[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.whole) begin
                r_mem[i_wr.addr[5:2]] <= i_wr.data;
            end else begin
                r_mem[i_wr.addr[5:2]][lane_lsb +: 8] <= i_wr.data[7:0];
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sha1h_core.sv -----
module sha1h_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1h_pkg::t_core_ctl i_ctl,
    input  logic [31:0]          i_blk_word,
    output logic [4:0][31:0]     o_chain
);
    import sha1h_pkg::*;

    logic [4:0][31:0] r_chain;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [31:0] w, f, k, tmp;

    always_comb begin
        if (i_ctl.t < 7'd16) begin
            w = i_blk_word;
        end else begin
            w = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 5'd1);
        end
        if (i_ctl.t < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (i_ctl.t < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (i_ctl.t < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        tmp = rotl(r_a, 5'd5) + f + r_e + w + k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_chain <= {H4, H3, H2, H1, H0};
        end else if (i_ctl.add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctl.round) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= rotl(r_b, 5'd30);
            r_b <= r_a;
            r_a <= tmp;
        end
        if (i_ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w;
        end
    end

    assign o_chain = r_chain;

endmodule

// ----- rtl/sha1_bitwise_message_hasher.sv -----
// Each append, restart or rejected item gives one result once it is accepted; an append
// that fills a block first runs the 80 compression rounds.
// A finish item runs the padding sweep and one or two compressions before its five digest
// words, one per cycle while the output is not stalled; a repeated finish sends them again.
// No new item is taken until the last result of the current one is in the output register.
// Reset (synchronous, active low) loads the initial hash words and clears all control.
module sha1_bitwise_message_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sha1h_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sha1h_pkg::t_out_item o_out_item
);
    import sha1h_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RESP = 7'b0000010,
        S_PRE  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_FILL = 7'b0100000,
        S_LEN  = 7'b1000000
    } t_state;

    // Phase after a compression finishes.
    localparam logic [1:0] PH_APPEND = 2'd0;
    localparam logic [1:0] PH_PAD1   = 2'd1;
    localparam logic [1:0] PH_FINAL  = 2'd2;

    t_state      r_state, n_state;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_pos, n_pos;
    logic [2:0]  r_off, n_off;
    logic [7:0]  r_cur, n_cur;
    logic        r_fin, n_fin;
    logic [1:0]  r_err, n_err;
    logic [1:0]  r_ph, n_ph;
    logic [6:0]  r_t, n_t;
    logic [6:0]  r_fp, n_fp;
    logic [5:0]  r_lim, n_lim;
    logic        r_dig, n_dig;
    logic [2:0]  r_k, n_k;
    logic        r_ov, n_ov;
    t_out_item   r_oitem, n_oitem;

    t_buf_wr          wr;
    t_core_ctl        ctl;
    logic [3:0]       raddr;
    logic [31:0]      rdata;
    logic [4:0][31:0] chain;

    logic        accept, ov_free;
    logic [3:0]  nb;
    logic [7:0]  mask, v, base, newb, padb;
    logic [15:0] spill;
    logic [4:0]  osum;
    logic [64:0] lsum;
    logic [6:0]  p1;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign ov_free    = !r_ov || !i_out_stall;

    always_comb begin
        nb    = (i_in_item.bit_count > 4'd8) ? 4'd8 : i_in_item.bit_count;
        mask  = ~(8'hff >> nb);
        v     = i_in_item.data_byte & mask;
        base  = (r_off == 3'd0) ? 8'h00 : r_cur;
        newb  = base | (v >> r_off);
        spill = {v, 8'h00} >> r_off;
        osum  = {2'b00, r_off} + {1'b0, nb};
        lsum  = {1'b0, r_len} + {61'd0, nb};
        padb  = base | (PAD_BYTE >> r_off);
        p1    = {1'b0, r_pos} + 7'd1;
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_pos   = r_pos;
        n_off   = r_off;
        n_cur   = r_cur;
        n_fin   = r_fin;
        n_err   = r_err;
        n_ph    = r_ph;
        n_t     = r_t;
        n_fp    = r_fp;
        n_lim   = r_lim;
        n_dig   = r_dig;
        n_k     = r_k;
        n_ov    = ov_free ? 1'b0 : r_ov;
        n_oitem = r_oitem;
        wr      = '0;
        ctl     = '0;
        ctl.t   = r_t;
        raddr   = 4'd0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESP;
                    n_dig   = 1'b0;
                    n_k     = 3'd0;
                    if (i_in_item.opcode == OP_RESTART) begin
                        ctl.init = 1'b1;
                        n_len = '0;
                        n_pos = '0;
                        n_off = '0;
                        n_cur = '0;
                        n_fin = 1'b0;
                        n_err = ST_OK;
                    end else if (i_in_item.opcode == OP_APPEND && r_err == ST_OK) begin
                        if (r_fin) begin
                            n_err = ST_AFTER_FINISH;
                        end else if (nb != 4'd0) begin
                            if (lsum[64]) begin
                                n_err = ST_TOO_LONG;
                            end else begin
                                n_len = lsum[63:0];
                                n_off = osum[2:0];
                                if (osum >= 5'd8) begin
                                    wr.en   = 1'b1;
                                    wr.addr = r_pos;
                                    wr.data = {24'd0, newb};
                                    n_cur   = spill[7:0];
                                    n_pos   = r_pos + 6'd1;
                                    if (r_pos == 6'd63) begin
                                        n_state = S_PRE;
                                        n_ph    = PH_APPEND;
                                    end
                                end else begin
                                    n_cur = newb;
                                end
                            end
                        end
                    end else if (i_in_item.opcode == OP_FINISH && r_err == ST_OK) begin
                        n_dig = 1'b1;
                        if (!r_fin) begin
                            wr.en   = 1'b1;
                            wr.addr = r_pos;
                            wr.data = {24'd0, padb};
                            n_fp    = p1;
                            if (p1 > 7'd56) begin
                                n_lim   = 6'd63;
                                n_ph    = PH_PAD1;
                                n_state = (p1 == 7'd64) ? S_PRE : S_FILL;
                            end else begin
                                n_lim   = 6'd55;
                                n_state = (p1 == 7'd56) ? S_LEN : S_FILL;
                            end
                        end
                    end
                end
            end
            S_FILL: begin
                wr.en   = 1'b1;
                wr.addr = r_fp[5:0];
                n_fp    = r_fp + 7'd1;
                if (r_fp[5:0] == r_lim) begin
                    n_fp    = 7'd56;
                    n_state = (r_lim == 6'd63) ? S_PRE : S_LEN;
                end
            end
            S_LEN: begin
                // Big-endian bit length in the last two words of the block.
                wr.en    = 1'b1;
                wr.whole = 1'b1;
                wr.addr  = r_fp[5:0];
                wr.data  = (r_fp == 7'd56) ? r_len[63:32] : r_len[31:0];
                n_fp     = 7'd60;
                if (r_fp != 7'd56) begin
                    n_ph    = PH_FINAL;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                ctl.load = 1'b1;
                raddr    = 4'd0;
                n_t      = 7'd0;
                n_state  = S_CMP;
            end
            S_CMP: begin
                ctl.round = 1'b1;
                raddr     = r_t[3:0] + 4'd1;
                n_t       = r_t + 7'd1;
                if (r_t == 7'(NUM_ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                ctl.add = 1'b1;
                n_pos   = 6'd0;
                case (r_ph)
                    PH_PAD1: begin
                        n_fp    = 7'd0;
                        n_lim   = 6'd55;
                        n_state = S_FILL;
                    end
                    PH_FINAL: begin
                        n_fin   = 1'b1;
                        n_off   = 3'd0;
                        n_cur   = 8'h00;
                        n_state = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_RESP: begin
                if (ov_free) begin
                    n_ov = 1'b1;
                    if (r_dig) begin
                        n_oitem.status      = ST_OK;
                        n_oitem.digest_word = chain[r_k];
                        n_oitem.last        = (r_k == 3'd4);
                        n_k                 = r_k + 3'd1;
                        if (r_k == 3'd4) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_oitem.status      = r_err;
                        n_oitem.digest_word = 32'd0;
                        n_oitem.last        = 1'b1;
                        n_state             = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pos   <= '0;
            r_off   <= '0;
            r_cur   <= '0;
            r_fin   <= 1'b0;
            r_err   <= ST_OK;
            r_ph    <= PH_APPEND;
            r_t     <= '0;
            r_fp    <= '0;
            r_lim   <= '0;
            r_dig   <= 1'b0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_off   <= n_off;
            r_cur   <= n_cur;
            r_fin   <= n_fin;
            r_err   <= n_err;
            r_ph    <= n_ph;
            r_t     <= n_t;
            r_fp    <= n_fp;
            r_lim   <= n_lim;
            r_dig   <= n_dig;
            r_k     <= n_k;
            r_ov    <= n_ov;
        end
        r_oitem <= n_oitem;
    end

    sha1h_buf u_buf (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sha1h_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_blk_word (rdata),
        .o_chain    (chain)
    );

    assign o_out_valid = r_ov;
    assign o_out_item  = r_oitem;

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_t < 7'(NUM_ROUNDS)))
        else $error("round counter out of range");

    a_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_off == 3'd0) |-> (r_cur == 8'h00))
        else $error("partial byte holds bits at a byte boundary");

    a_digest_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_dig) |-> (r_k <= 3'd4))
        else $error("digest word index out of range");

    a_cmp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_t == 7'(NUM_ROUNDS - 1)) |=> (r_state == S_ADD))
        else $error("compression did not end after the last round");

endmodule

// ----- tb/sv/sha1_bitwise_message_hasher_tb.sv -----
`timescale 1ns / 1ps

module sha1_bitwise_message_hasher_tb;
    import sha1h_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    sha1_bitwise_message_hasher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Predictor state.
    logic [31:0] hash_h [5];
    logic [7:0]  msg_buf [64];
    logic [63:0] msg_bits;
    int          buf_pos;
    int          bit_pos;
    logic        done_flag;
    logic [1:0]  err_code;

    t_out_item   pending_words [$];
    int          mismatch_count;
    int          directed_count;

    typedef struct {
        t_in_item  item;
        logic      has_value;
        t_out_item value;
    } t_row;

    function automatic logic [31:0] rol(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic hash_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, w_t, tmp;
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w_t = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
            end else begin
                w_t = rol(w[(t-3)&15] ^ w[(t-8)&15] ^ w[(t-14)&15] ^ w[t&15], 1);
            end
            w[t&15] = w_t;
            if (t < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            tmp = rol(a, 5) + f + e + w_t + k;
            e = d; d = c; c = rol(b, 30); b = a; a = tmp;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
        buf_pos = 0;
    endtask

    task automatic clear_hasher();
        hash_h[0] = H0; hash_h[1] = H1; hash_h[2] = H2; hash_h[3] = H3; hash_h[4] = H4;
        for (int i = 0; i < 64; i++) msg_buf[i] = '0;
        msg_bits = '0; buf_pos = 0; bit_pos = 0; done_flag = 0; err_code = ST_OK;
    endtask

    task automatic pack_bits(input logic [7:0] bits, input int n);
        logic [7:0] v;
        v = bits & (8'hff << (8 - n));
        if (bit_pos == 0) msg_buf[buf_pos] = '0;
        msg_buf[buf_pos] |= v >> bit_pos;
        if (bit_pos + n >= 8) begin
            buf_pos++;
            if (buf_pos >= 64) hash_block();
            msg_buf[buf_pos] = v << (8 - bit_pos);
        end
        bit_pos = (bit_pos + n) & 7;
    endtask

    task automatic pad_and_close();
        logic [63:0] len;
        len = msg_bits;
        if (bit_pos == 0) msg_buf[buf_pos] = PAD_BYTE;
        else msg_buf[buf_pos] |= PAD_BYTE >> bit_pos;
        buf_pos++;
        if (buf_pos > 56) begin
            for (int i = buf_pos; i < 64; i++) msg_buf[i] = '0;
            hash_block();
            for (int i = 0; i < 56; i++) msg_buf[i] = '0;
        end else begin
            for (int i = buf_pos; i < 56; i++) msg_buf[i] = '0;
        end
        for (int i = 63; i > 55; i--) begin
            msg_buf[i] = len[7:0];
            len = len >> 8;
        end
        hash_block();
        done_flag = 1;
        for (int i = 0; i < 64; i++) msg_buf[i] = '0;
        buf_pos = 0; bit_pos = 0;
    endtask

    task automatic predict_hash(input t_in_item it);
        int n;
        logic [63:0] sum;
        if (it.opcode == OP_RESTART) begin
            clear_hasher();
            pending_words.push_back('{ST_OK, 32'd0, 1'b1});
        end else if (it.opcode == OP_UNUSED || err_code != ST_OK) begin
            pending_words.push_back('{err_code, 32'd0, 1'b1});
        end else if (it.opcode == OP_APPEND) begin
            if (done_flag) begin
                err_code = ST_AFTER_FINISH;
            end else begin
                n = (it.bit_count > 8) ? 8 : it.bit_count;
                if (n != 0) begin
                    sum = msg_bits + 64'(n);
                    if (sum < msg_bits) begin
                        err_code = ST_TOO_LONG;
                    end else begin
                        msg_bits = sum;
                        pack_bits(it.data_byte, n);
                    end
                end
            end
            pending_words.push_back('{err_code, 32'd0, 1'b1});
        end else begin
            if (!done_flag) pad_and_close();
            for (int k = 0; k < 5; k++)
                pending_words.push_back('{ST_OK, hash_h[k], k == 4});
        end
    endtask

    // Called at a falling edge; valid stays high into the next item when there is no gap.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_hash(it);
        @(negedge i_clk);
    endtask

    function automatic t_in_item append_item(input logic [7:0] d, input logic [3:0] n);
        return '{OP_APPEND, d, n};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("sha1_bitwise_message_hasher test failed");
        $finish;
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_out_item);
            end else begin
                want = pending_words.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.digest_word !== want.digest_word ||
                    o_out_item.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected st=%0d w=%h l=%0d, got st=%0d w=%h l=%0d",
                                 want.status, want.digest_word, want.last,
                                 o_out_item.status, o_out_item.digest_word,
                                 o_out_item.last);
                end
            end
        end
    end

    // Output stall: a per-result wait, with quiet stretches.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (hold != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        t_in_item it;
        int kind;
        int len;
        mismatch_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        clear_hasher();

        // Empty message digest, then extremes and special cases (the too-long case is not driven).
        rows.push_back('{'{OP_FINISH, 8'h00, 4'd0}, 1'b0, '0});
        rows.push_back('{'{OP_FINISH, 8'hff, 4'd15}, 1'b0, '0});
        rows.push_back('{append_item(8'hff, 4'd8), 1'b1, '{ST_AFTER_FINISH, 32'd0, 1'b1}});
        rows.push_back('{'{OP_FINISH, 8'h00, 4'd0}, 1'b1, '{ST_AFTER_FINISH, 32'd0, 1'b1}});
        rows.push_back('{'{OP_RESTART, 8'hff, 4'd15}, 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'h61, 4'd8), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'h62, 4'd8), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'h63, 4'd8), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{'{OP_FINISH, 8'h00, 4'd0}, 1'b0, '0});
        rows.push_back('{'{OP_RESTART, 8'h00, 4'd0}, 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'hff, 4'd1), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'h00, 4'd0), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'h5a, 4'd3), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'ha5, 4'd12), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{append_item(8'h00, 4'd7), 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{'{OP_UNUSED, 8'hff, 4'd15}, 1'b1, '{ST_OK, 32'd0, 1'b1}});
        rows.push_back('{'{OP_FINISH, 8'h00, 4'd0}, 1'b0, '0});
        rows.push_back('{'{OP_RESTART, 8'h00, 4'd0}, 1'b1, '{ST_OK, 32'd0, 1'b1}});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r]) begin
            send_item(rows[r].item);
            // The newest prediction is still queued: its result cannot have left yet.
            if (rows[r].has_value && pending_words[$] !== rows[r].value) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("row %0d: table expects %h, predictor %h",
                             r, rows[r].value, pending_words[$]);
            end
        end

        // Random messages: random run of mostly appends, a finish, maybe another item, a restart.
        directed_count = 0;
        while (directed_count < 500) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 20);
            for (int i = 0; i < len && directed_count < 500; i++) begin
                kind = $urandom_range(0, 49);
                it = '{OP_APPEND, 8'($urandom), 4'($urandom_range(1, 8))};
                if (kind == 0) it.bit_count = 4'($urandom_range(0, 15));
                else if (kind == 1) it.opcode = OP_UNUSED;
                send_item(it);
                directed_count++;
            end
            send_item('{OP_FINISH, 8'($urandom), 4'($urandom)});
            if ($urandom_range(0, 3) == 0)
                send_item('{($urandom_range(0, 1) ? OP_FINISH : OP_APPEND),
                            8'($urandom), 4'($urandom)});
            send_item('{OP_RESTART, 8'($urandom), 4'($urandom)});
            directed_count += 3;
        end
        i_in_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("sha1_bitwise_message_hasher test passed");
        end else begin
            $display("sha1_bitwise_message_hasher test failed");
        end
        $finish;
    end

endmodule
